// ===== design/mp2d_pkg.sv =====
`default_nettype none

package mp2d_pkg;

  localparam int POS_W       = 6;
  localparam int LAYER_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int WIN_W       = 3;
  localparam int LEN_W       = 7;
  localparam int RECIP_SHIFT = 12;
  localparam int RECIP_W     = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_HEIGHT = 3'd0,
    CFG_WINDOW_WIDTH  = 3'd1,
    CFG_ROW_STRIDE    = 3'd2,
    CFG_COL_STRIDE    = 3'd3,
    CFG_LAYER_ROWS    = 3'd4,
    CFG_LAYER_COLS    = 3'd5
  } cfg_idx_e;

  // ceil(2^RECIP_SHIFT / stride); exact quotient and remainder test for
  // numerators below 64. A zero stride acts as one.
  function automatic logic [RECIP_W-1:0] stride_recip(input logic [WIN_W-1:0] stride);
    logic [RECIP_W-1:0] r;
    case (stride)
      3'd2:    r = 13'd2048;
      3'd3:    r = 13'd1366;
      3'd4:    r = 13'd1024;
      3'd5:    r = 13'd820;
      3'd6:    r = 13'd683;
      3'd7:    r = 13'd586;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/mp2d_ram.sv =====
`default_nettype none

module mp2d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/max_pool_2d_stream.sv =====
// Streaming 2-D max pooling.
// s_axis carries one signed activation per item in layer, row, column raster
// order. m_axis carries one pooled result per completed window on the stride
// grid: tdata = {out_col, out_row, out_layer, pooled_max}, tlast marks the last
// window of a layer. Windows that do not fit fully inside the layer are skipped.
// The cfg channel writes geometry registers (index 0..5: window height/width,
// row/col stride, layer rows/cols); cfg_ready_o is always high. Write it only
// while no items are in flight.
// Throughput: one item per cycle while m_axis is not stalled. Pipeline is input
// stage (history RAM read and vertical max), horizontal max stage, output
// register; a result is registered in each of these before it shows on m_axis.
// The history RAM holds MAX_WINDOW-1 previous rows per column and is read and
// rewritten once per item through a single read and a single write port, with
// forwarding for a one-column layer.
// Reset zeroes the position counters and layer index and loads the default
// geometry (2x2 window, stride 2, 64x64 layer); history contents are left as is.
// When m_axis stalls the stages hold and s_axis_tready drops once the pipeline
// stages ahead of the output register are full.
`default_nettype none

module max_pool_2d_stream
  import mp2d_pkg::*;
#(
  parameter int MAX_COLS   = 64,
  parameter int MAX_WINDOW = 4,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample_value
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // pooled_max, out_layer, out_row, out_col
  output logic [((DATA_WIDTH+LAYER_W+2*POS_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                                       m_axis_tlast,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                      cfg_data_i
);

  localparam int HD      = MAX_WINDOW - 1;
  localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PW      = $clog2(MAX_WINDOW);
  localparam int LEN_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int WIN_CAP = (MAX_WINDOW > 7) ? 7 : MAX_WINDOW;
  localparam int OUT_W   = ((DATA_WIDTH + LAYER_W + 2 * POS_W + 7) / 8) * 8;
  localparam int PAD_W   = OUT_W - (DATA_WIDTH + LAYER_W + 2 * POS_W);

  typedef logic [HD-1:0][DATA_WIDTH-1:0] hist_row_t;

  // configuration
  logic [WIN_W-1:0] win_h_q, win_w_q, row_stride_q, col_stride_q;
  logic [LEN_W-1:0] layer_rows_q, layer_cols_q;
  logic [WIN_W-1:0] wh, ww, rs, cs;
  logic [LEN_W-1:0] rows, cols;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_h_q      <= 3'd2;
      win_w_q      <= 3'd2;
      row_stride_q <= 3'd2;
      col_stride_q <= 3'd2;
      layer_rows_q <= 7'd64;
      layer_cols_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_HEIGHT: win_h_q      <= cfg_data_i[WIN_W-1:0];
        CFG_WINDOW_WIDTH:  win_w_q      <= cfg_data_i[WIN_W-1:0];
        CFG_ROW_STRIDE:    row_stride_q <= cfg_data_i[WIN_W-1:0];
        CFG_COL_STRIDE:    col_stride_q <= cfg_data_i[WIN_W-1:0];
        CFG_LAYER_ROWS:    layer_rows_q <= cfg_data_i[LEN_W-1:0];
        CFG_LAYER_COLS:    layer_cols_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign wh   = (win_h_q == '0) ? 3'd1 :
                (win_h_q > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : win_h_q;
  assign ww   = (win_w_q == '0) ? 3'd1 :
                (win_w_q > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : win_w_q;
  assign rs   = (row_stride_q == '0) ? 3'd1 : row_stride_q;
  assign cs   = (col_stride_q == '0) ? 3'd1 : col_stride_q;
  assign rows = (layer_rows_q == '0) ? 7'd1 :
                (layer_rows_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : layer_rows_q;
  assign cols = (layer_cols_q == '0) ? 7'd1 :
                (layer_cols_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : layer_cols_q;

  // handshake chain
  logic accept, s1_adv, s2_adv;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign s2_adv        = !out_valid_q || m_axis_tready;
  assign s1_adv        = !s2_valid_q || s2_adv;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // position counters
  logic [POS_W-1:0]   row_q, row_d, col_q, col_d;
  logic [LAYER_W-1:0] layer_q, layer_d;
  logic [PW-1:0]      cmod_q, cmod_d;
  logic [POS_W:0]     col_inc, row_inc;

  assign col_inc = {1'b0, col_q} + 7'd1;
  assign row_inc = {1'b0, row_q} + 7'd1;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    layer_d = layer_q;
    cmod_d  = cmod_q;
    if (col_inc >= cols) begin
      col_d  = '0;
      cmod_d = '0;
      if (row_inc >= rows) begin
        row_d   = '0;
        layer_d = layer_q + 8'd1;
      end else begin
        row_d = row_inc[POS_W-1:0];
      end
    end else begin
      col_d = col_inc[POS_W-1:0];
      if (col_inc[POS_W] || cmod_q == PW'(MAX_WINDOW - 1)) begin
        cmod_d = '0;
      end else begin
        cmod_d = cmod_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      layer_q <= '0;
      cmod_q  <= '0;
    end else if (accept) begin
      row_q   <= row_d;
      col_q   <= col_d;
      layer_q <= layer_d;
      cmod_q  <= cmod_d;
    end
  end

  // stage 1: item plus history row read
  logic signed [DATA_WIDTH-1:0] s1_x_q;
  logic [POS_W-1:0]             s1_row_q, s1_col_q;
  logic [LAYER_W-1:0]           s1_layer_q;
  logic [PW-1:0]                s1_cmod_q;
  logic                         fwd_hit_q;
  hist_row_t                    fwd_row_q;
  hist_row_t                    ram_rdata, hist, new_row;
  logic                         mem_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= s_axis_tdata[DATA_WIDTH-1:0];
      s1_row_q   <= row_q;
      s1_col_q   <= col_q;
      s1_layer_q <= layer_q;
      s1_cmod_q  <= cmod_q;
      fwd_hit_q  <= mem_we && (AW'(s1_col_q) == AW'(col_q));
      fwd_row_q  <= new_row;
    end
  end

  mp2d_ram #(
    .WIDTH(HD * DATA_WIDTH),
    .DEPTH(MAX_COLS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(AW'(s1_col_q)),
    .wdata_i(new_row),
    .re_i   (accept),
    .raddr_i(AW'(col_q)),
    .rdata_o(ram_rdata)
  );

  assign hist = fwd_hit_q ? fwd_row_q : ram_rdata;

  logic                         in_range, row_ok, col_ok, div_r, div_c, last_r, last_c;
  logic                         produce;
  logic signed [DATA_WIDTH-1:0] vm;
  logic [POS_W:0]               orow_w, ocol_w;
  logic [POS_W-1:0]             orow, ocol;
  logic [RECIP_W-1:0]           recip_r, recip_c;
  logic [POS_W+RECIP_W-1:0]     prod_r, prod_c;

  assign in_range = ({1'b0, s1_row_q} < rows) && ({1'b0, s1_col_q} < cols);

  always_comb begin
    vm         = s1_x_q;
    new_row[0] = s1_x_q;
    for (int k = 0; k < HD; k++) begin
      if (k + 1 < int'(wh) && $signed(hist[k]) > vm) begin
        vm = $signed(hist[k]);
      end
      if (k > 0) begin
        new_row[k] = hist[k-1];
      end
    end
  end

  assign row_ok = {1'b0, s1_row_q} + 7'd1 >= {4'b0, wh};
  assign col_ok = {1'b0, s1_col_q} + 7'd1 >= {4'b0, ww};
  assign orow_w = {1'b0, s1_row_q} + 7'd1 - {4'b0, wh};
  assign ocol_w = {1'b0, s1_col_q} + 7'd1 - {4'b0, ww};
  assign orow   = orow_w[POS_W-1:0];
  assign ocol   = ocol_w[POS_W-1:0];

  assign recip_r = stride_recip(rs);
  assign recip_c = stride_recip(cs);
  assign prod_r  = (POS_W+RECIP_W)'(orow) * (POS_W+RECIP_W)'(recip_r);
  assign prod_c  = (POS_W+RECIP_W)'(ocol) * (POS_W+RECIP_W)'(recip_c);
  assign div_r   = {1'b0, prod_r[RECIP_SHIFT-1:0]} < recip_r;
  assign div_c   = {1'b0, prod_c[RECIP_SHIFT-1:0]} < recip_c;

  assign last_r = ({2'b0, orow} + {5'b0, rs} + {5'b0, wh}) > {1'b0, rows};
  assign last_c = ({2'b0, ocol} + {5'b0, cs} + {5'b0, ww}) > {1'b0, cols};

  assign produce = in_range && row_ok && col_ok && div_r && div_c;
  assign mem_we  = s1_valid_q && s1_adv && in_range;

  // ring of vertical maxima, indexed by column modulo MAX_WINDOW
  logic signed [DATA_WIDTH-1:0] ring_q [MAX_WINDOW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        ring_q[i] <= '0;
      end
    end else if (mem_we) begin
      ring_q[s1_cmod_q] <= vm;
    end
  end

  // stage 2: horizontal max
  logic signed [DATA_WIDTH-1:0] s2_vm_q, wmax;
  logic [PW-1:0]                s2_cmod_q;
  logic [LAYER_W-1:0]           s2_layer_q;
  logic [POS_W-1:0]             s2_orow_q, s2_ocol_q;
  logic                         s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= s1_valid_q && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_vm_q    <= vm;
      s2_cmod_q  <= s1_cmod_q;
      s2_layer_q <= s1_layer_q;
      s2_orow_q  <= prod_r[RECIP_SHIFT +: POS_W];
      s2_ocol_q  <= prod_c[RECIP_SHIFT +: POS_W];
      s2_last_q  <= last_r && last_c;
    end
  end

  always_comb begin
    logic [PW:0] col_back;
    wmax = s2_vm_q;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (s2_cmod_q >= PW'(i)) begin
        col_back = {1'b0, s2_cmod_q} - (PW+1)'(i);
      end else begin
        col_back = {1'b0, s2_cmod_q} + (PW+1)'(MAX_WINDOW) - (PW+1)'(i);
      end
      if (col_back != '0 && 32'(col_back) < 32'(ww) && ring_q[i] > wmax) begin
        wmax = ring_q[i];
      end
    end
  end

  // output register
  logic [DATA_WIDTH-1:0] out_max_q;
  logic [LAYER_W-1:0]    out_layer_q;
  logic [POS_W-1:0]      out_row_q, out_col_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_valid_q) begin
      out_max_q   <= wmax;
      out_layer_q <= s2_layer_q;
      out_row_q   <= s2_orow_q;
      out_col_q   <= s2_ocol_q;
      out_last_q  <= s2_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_col_q, out_row_q, out_layer_q, out_max_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== design/mp2d_checker.sv =====
`default_nettype none

module mp2d_checker #(
  parameter int IN_W  = 16,
  parameter int OUT_W = 40
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [IN_W-1:0]  s_axis_tdata,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tlast
);

  logic seen_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      seen_in_q <= 1'b1;
    end
  end

  // nothing leaves the block during reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a free output side never blocks the input side
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  // every result traces back to some accepted item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_in_q)
    else $error("result without any accepted item");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  logic unused_in;
  assign unused_in = ^s_axis_tdata;

endmodule

bind max_pool_2d_stream mp2d_checker #(
  .IN_W (((DATA_WIDTH + 7) / 8) * 8),
  .OUT_W(((DATA_WIDTH + 20 + 7) / 8) * 8)
) u_mp2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
